/* src/noise_gate_envelope_gain_macros.svh */
// Assertion macros for the noise gate block.
`ifndef NOISE_GATE_ENVELOPE_GAIN_MACROS_SVH
`define NOISE_GATE_ENVELOPE_GAIN_MACROS_SVH
`ifndef SYNTHESIS
`define NG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("noise gate assertion failed");
`define NG_ASSERT_IMP(lbl, pre, post) `NG_ASSERT(lbl, (pre) |-> (post))
`else
`define NG_ASSERT(lbl, prop)
`define NG_ASSERT_IMP(lbl, pre, post)
`endif
`endif

/* src/ngeg_pkg.sv */
`timescale 1ns / 1ps
package ngeg_pkg;

  localparam int ThrBits   = 31;
  localparam int RatioBits = 17;
  localparam int EnvBits   = 32;
  localparam int GainBits  = 17;
  localparam int CfgBits   = 31;
  localparam int CfgIdxBits = 2;
  // envelope * ratio
  localparam int NumBits   = EnvBits + RatioBits;

  localparam logic [CfgIdxBits-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CfgIdxBits-1:0] REG_ATTACK    = 2'd1;
  localparam logic [CfgIdxBits-1:0] REG_RELEASE   = 2'd2;
  localparam logic [CfgIdxBits-1:0] REG_RATIO     = 2'd3;

  localparam logic [ThrBits-1:0]   THR_RESET     = 31'd67108864;
  localparam logic [RatioBits-1:0] RATIO_RESET   = 17'd1311;
  localparam logic [15:0]          ATTACK_RESET  = 16'd53216;
  localparam logic [15:0]          RELEASE_RESET = 16'd65532;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_ENV   = 11'b000_0000_0010,
    ST_EUPD  = 11'b000_0000_0100,
    ST_RMUL  = 11'b000_0000_1000,
    ST_TGT   = 11'b000_0001_0000,
    ST_DIV   = 11'b000_0010_0000,
    ST_GSET  = 11'b000_0100_0000,
    ST_GEMA  = 11'b000_1000_0000,
    ST_GUPD  = 11'b001_0000_0000,
    ST_OMUL  = 11'b010_0000_0000,
    ST_EMIT  = 11'b100_0000_0000
  } state_e;

endpackage

/* src/noise_gate_envelope_gain.sv */
`timescale 1ns / 1ps
// Processes one sample at a time: s_axis_tready is high only in ST_IDLE, so a new
// sample is taken only after the last one is emitted; an output stall holds ST_EMIT.
// The 49-step divide runs only when the envelope is not above threshold; the shared
// shift-add multiplier and the one-bit-per-cycle restoring divider serialize the work.
// Reset (async, active low): envelope and gain to zero, registers to defaults.
`include "noise_gate_envelope_gain_macros.svh"
module noise_gate_envelope_gain #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [ngeg_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [ngeg_pkg::CfgBits-1:0]  cfg_data_i,
  // input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,  // sample
  // output stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [((SAMPLE_BITS+17+7)/8)*8-1:0]   m_axis_tdata   // out_sample, gain_now
);

  localparam int S     = SAMPLE_BITS;
  localparam int F     = COEF_FRAC_BITS;
  localparam int OUT_W = ((S + 17 + 7) / 8) * 8;
  localparam int NW    = ngeg_pkg::NumBits;
  localparam int GB    = ngeg_pkg::GainBits;
  localparam int TB    = ngeg_pkg::ThrBits;
  localparam int EB    = ngeg_pkg::EnvBits;
  localparam int RB    = ngeg_pkg::RatioBits;
  // accumulator holds signed EMA deltas and full products
  localparam int AW    = (S + F + 2 > NW + 2) ? S + F + 2 : NW + 2;
  localparam int MRW   = (F > RB) ? F : RB;
  localparam int CW    = $clog2(NW);
  // the sum wraps like a 64-bit product before the >> F
  localparam int WRAPW = 64 - F;
  localparam logic [AW-1:0] WRAP_MASK =
    (WRAPW >= AW) ? {AW{1'b1}} : ((AW'(1) << WRAPW) - AW'(1));
  localparam logic [AW-1:0] ENV_MAX   = AW'({EB{1'b1}});
  localparam logic [GB-1:0] GAIN_FLOOR = GB'(((1 << F) + 500) / 1000);
  localparam logic [NW-1:0] ONE_T      = NW'(1) << F;

  ngeg_pkg::state_e state_q, state_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [AW-1:0]  acc_q, acc_d, md_q, md_d;
  logic [MRW-1:0] mr_q, mr_d;
  logic [S-1:0]   mag_q, mag_d;
  logic           neg_q, neg_d;
  logic [EB-1:0]  env_q, env_d;
  logic [GB-1:0]  gain_q, gain_d;
  logic [NW-1:0]  tgt_q, tgt_d, num_q, num_d;
  logic [TB-1:0]  rem_q, rem_d;
  logic [TB-1:0]  thr_q;
  logic [F-1:0]   att_q, rel_q;
  logic [RB-1:0]  ratio_q;
  logic [S-1:0]   osmp_q, osmp_d;
  logic [GB-1:0]  ogain_q, ogain_d;
  logic           ovalid_q, ovalid_d;

  logic [TB-1:0]  thr_eff;
  logic [S-1:0]   raw, mag_in;
  logic [AW-1:0]  axx, addend, sum, upd, wrapped, prod, limit;
  logic [EB:0]    trial;
  logic           ge;
  logic [EB-1:0]  env_new;
  logic [GB-1:0]  gain_new;
  logic [S-1:0]   pmag;

  assign thr_eff = (thr_q == '0) ? TB'(1) : thr_q;
  assign raw     = s_axis_tdata[S-1:0];
  assign mag_in  = raw[S-1] ? (~raw + S'(1)) : raw;

  // shared serial adder: right-shift for EMA steps, left-shift for products
  assign addend = (state_q == ngeg_pkg::ST_RMUL || state_q == ngeg_pkg::ST_OMUL)
                ? (mr_q[MRW-1] ? md_q : '0) : (mr_q[0] ? md_q : '0);
  assign sum    = (state_q == ngeg_pkg::ST_RMUL || state_q == ngeg_pkg::ST_OMUL)
                ? ((acc_q << 1) + addend) : (acc_q + addend);

  // divider step
  assign trial = {1'b0, rem_q, num_q[NW-1]};
  assign ge    = trial >= {2'b00, thr_eff};

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    md_d     = md_q;
    mr_d     = mr_q;
    mag_d    = mag_q;
    neg_d    = neg_q;
    env_d    = env_q;
    gain_d   = gain_q;
    tgt_d    = tgt_q;
    num_d    = num_q;
    rem_d    = rem_q;
    osmp_d   = osmp_q;
    ogain_d  = ogain_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    axx      = '0;
    upd      = '0;
    wrapped  = '0;
    env_new  = '0;
    gain_new = '0;
    prod     = '0;
    limit    = '0;
    pmag     = '0;

    unique case (state_q)
      ngeg_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          axx   = AW'(mag_in) << F;
          mag_d = mag_in;
          neg_d = raw[S-1];
          mr_d  = (axx > AW'(env_q)) ? MRW'(att_q) : MRW'(rel_q);
          md_d  = AW'(env_q) - axx;
          acc_d = '0;
          cnt_d = CW'(F - 1);
          state_d = ngeg_pkg::ST_ENV;
        end
      end
      ngeg_pkg::ST_ENV, ngeg_pkg::ST_GEMA: begin
        acc_d = AW'($signed(sum) >>> 1);
        mr_d  = mr_q >> 1;
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          state_d = (state_q == ngeg_pkg::ST_ENV) ? ngeg_pkg::ST_EUPD : ngeg_pkg::ST_GUPD;
        end
      end
      ngeg_pkg::ST_EUPD: begin
        upd     = (AW'(mag_q) << F) + acc_q;
        wrapped = upd & WRAP_MASK;
        env_new = (wrapped > ENV_MAX) ? {EB{1'b1}} : wrapped[EB-1:0];
        env_d   = env_new;
        md_d    = AW'(env_new);
        mr_d    = MRW'(ratio_q) << (MRW - RB);
        acc_d   = '0;
        cnt_d   = CW'(RB - 1);
        state_d = ngeg_pkg::ST_RMUL;
      end
      ngeg_pkg::ST_RMUL, ngeg_pkg::ST_OMUL: begin
        acc_d = sum;
        mr_d  = mr_q << 1;
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          state_d = (state_q == ngeg_pkg::ST_RMUL) ? ngeg_pkg::ST_TGT : ngeg_pkg::ST_EMIT;
        end
      end
      ngeg_pkg::ST_TGT: begin
        if (env_q > EB'(thr_eff)) begin
          tgt_d   = ONE_T;
          state_d = ngeg_pkg::ST_GSET;
        end else begin
          num_d   = acc_q[NW-1:0];
          rem_d   = '0;
          cnt_d   = CW'(NW - 1);
          state_d = ngeg_pkg::ST_DIV;
        end
      end
      ngeg_pkg::ST_DIV: begin
        rem_d = ge ? TB'(trial - {2'b00, thr_eff}) : trial[TB-1:0];
        num_d = {num_q[NW-2:0], ge};
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          tgt_d   = {num_q[NW-2:0], ge};
          state_d = ngeg_pkg::ST_GSET;
        end
      end
      ngeg_pkg::ST_GSET: begin
        mr_d    = (tgt_q > NW'(gain_q)) ? MRW'(att_q) : MRW'(rel_q);
        md_d    = AW'(gain_q) - AW'(tgt_q);
        acc_d   = '0;
        cnt_d   = CW'(F - 1);
        state_d = ngeg_pkg::ST_GEMA;
      end
      ngeg_pkg::ST_GUPD: begin
        upd      = AW'(tgt_q) + acc_q;
        wrapped  = upd & WRAP_MASK;
        gain_new = (wrapped < AW'(GAIN_FLOOR)) ? GAIN_FLOOR : wrapped[GB-1:0];
        gain_d   = gain_new;
        md_d     = AW'(mag_q);
        mr_d     = MRW'(gain_new) << (MRW - GB);
        acc_d    = '0;
        cnt_d    = CW'(GB - 1);
        state_d  = ngeg_pkg::ST_OMUL;
      end
      ngeg_pkg::ST_EMIT: begin
        prod  = acc_q >> F;
        limit = neg_q ? (AW'(1) << (S - 1)) : ((AW'(1) << (S - 1)) - AW'(1));
        pmag  = (prod > limit) ? limit[S-1:0] : prod[S-1:0];
        if (!ovalid_q || m_axis_tready) begin
          osmp_d   = neg_q ? (~pmag + S'(1)) : pmag;
          ogain_d  = gain_q;
          ovalid_d = 1'b1;
          state_d  = ngeg_pkg::ST_IDLE;
        end
      end
      default: state_d = ngeg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ngeg_pkg::ST_IDLE;
      cnt_q    <= '0;
      env_q    <= '0;
      gain_q   <= '0;
      ovalid_q <= 1'b0;
      thr_q    <= ngeg_pkg::THR_RESET;
      att_q    <= F'(ngeg_pkg::ATTACK_RESET);
      rel_q    <= F'(ngeg_pkg::RELEASE_RESET);
      ratio_q  <= ngeg_pkg::RATIO_RESET;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      env_q    <= env_d;
      gain_q   <= gain_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ngeg_pkg::REG_THRESHOLD: thr_q   <= cfg_data_i[TB-1:0];
          ngeg_pkg::REG_ATTACK:    att_q   <= cfg_data_i[F-1:0];
          ngeg_pkg::REG_RELEASE:   rel_q   <= cfg_data_i[F-1:0];
          ngeg_pkg::REG_RATIO:     ratio_q <= cfg_data_i[RB-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    md_q    <= md_d;
    mr_q    <= mr_d;
    mag_q   <= mag_d;
    neg_q   <= neg_d;
    tgt_q   <= tgt_d;
    num_q   <= num_d;
    rem_q   <= rem_d;
    osmp_q  <= osmp_d;
    ogain_q <= ogain_d;
  end

  assign s_axis_tready = (state_q == ngeg_pkg::ST_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = OUT_W'({ogain_q, osmp_q});

  `NG_ASSERT_IMP(a_accept_starts_env, s_axis_tvalid && s_axis_tready, ##1 state_q == ngeg_pkg::ST_ENV)
  `NG_ASSERT_IMP(a_out_from_emit, $rose(ovalid_q), $past(state_q == ngeg_pkg::ST_EMIT))
  `NG_ASSERT_IMP(a_rem_below_thr, state_q == ngeg_pkg::ST_DIV, rem_q < thr_eff)
  `NG_ASSERT_IMP(a_ema_count, state_q == ngeg_pkg::ST_ENV || state_q == ngeg_pkg::ST_GEMA, cnt_q < CW'(F))

endmodule
